@@ hw/rtl/ccta_pkg.sv @@
// ccta_pkg: shared constants, operation and status codes and sequencer states
// for the cluster chain table allocator; used by the top level
`default_nettype none
package ccta_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 4096;

    localparam logic [31:0] ENTRY_FREE         = 32'h0000_0000;
    localparam logic [31:0] ENTRY_EOC          = 32'h0FFF_FFFF;
    localparam logic [31:0] MEDIA_WORD         = 32'h0FFF_FFF8;
    localparam int          FIRST_DATA_CLUSTER = 2;

    localparam logic [12:0] CLUSTER_COUNT_RESET = 13'd4096;
    localparam int          CLUSTER_COUNT_MIN   = 3;

    typedef enum logic [3:0] {
        FN_FORMAT      = 4'd0,
        FN_LOAD        = 4'd1,
        FN_ALLOC       = 4'd2,
        FN_ALLOC_CHAIN = 4'd3,
        FN_APPEND      = 4'd4,
        FN_LENGTH      = 4'd5,
        FN_SET_END     = 4'd6,
        FN_SET_FREE    = 4'd7,
        FN_READ        = 4'd8,
        FN_COUNT_FREE  = 4'd9
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_LOOP  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FMT,
        S_FMT0,
        S_FMT1,
        S_WR,
        S_RD,
        S_RD_CHK,
        S_AL_RD,
        S_AL_CHK,
        S_AL_LINK,
        S_WK_RD,
        S_WK_CHK,
        S_WK_WR,
        S_CF_RD,
        S_CF_CHK,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/ccta_table_ram.sv @@
// ccta_table_ram: single-port link table, one read or write per cycle,
// registered read data; no package dependency
`default_nettype none
module ccta_table_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [31:0]   wdata,
    output logic      [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ hw/rtl/cluster_chain_table_allocator_core.sv @@
// cluster_chain_table_allocator_core: top level, sequencer and datapath
// depends on ccta_pkg and ccta_table_ram
//
//   channel | signals                                             | dir
//   in      | in_valid, in_stall, func, cluster, other_cluster,   | in
//           | entry_value, chain_length                           |
//   out     | out_valid, out_stall, status, result_value          | out
//   cfg     | cfg_write_en, cfg_write_data                        | in
//
// one request at a time; the table ram is the only memory port
// load/set: a write; read: a read, then a check; bad func or index: done
// alloc: a read and a check per entry scanned plus a link write per link
// length/append: read+check per link; count free: read+check per entry
// reset needs no table clear; the cursor resets to one
// a finished result waits in the output register while the next request runs
`default_nettype none
module cluster_chain_table_allocator_core #(
    parameter int TABLE_DEPTH = ccta_pkg::TABLE_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  func,
    input  wire logic [11:0] cluster,
    input  wire logic [11:0] other_cluster,
    input  wire logic [31:0] entry_value,
    input  wire logic [12:0] chain_length,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      result_value,
    input  wire logic        cfg_write_en,
    input  wire logic [12:0] cfg_write_data
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int ECW = $clog2(TABLE_DEPTH + 1);

    ccta_pkg::state_t  state_reg, state_next;
    ccta_pkg::func_t   func_reg;
    ccta_pkg::status_t st_reg;

    logic [12:0]    cluster_count_reg;
    logic [AW-1:0]  cursor_reg;
    logic [ECW-1:0] ec_reg;
    logic [ECW-1:0] ec_comb;
    logic [AW-1:0]  scan_reg;
    logic [AW-1:0]  prev_reg;
    logic [AW-1:0]  cur_reg;
    logic [ECW-1:0] n_reg;
    logic [ECW-1:0] steps_reg;
    logic [ECW-1:0] cnt_free_reg;
    logic [12:0]    want_reg;
    logic [12:0]    got_cnt_reg;
    logic [31:0]    wr_data_reg;
    logic [31:0]    oc_reg;
    logic [31:0]    res_reg;
    logic           out_valid_reg;
    logic [1:0]     status_reg;
    logic [31:0]    result_value_reg;

    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [31:0]    ram_wdata;
    logic [31:0]    ram_rdata;

    logic           accept;
    logic           cl_bad;
    logic           oc_bad;
    logic [AW-1:0]  scan_inc;
    logic [AW-1:0]  alloc_start;
    logic [ECW-1:0] cursor_inc;
    logic           scan_last;
    logic           rd_free;
    logic           rd_eof;
    logic           out_free;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x,
                                               input logic [ECW-1:0] ec);
        logic [ECW-1:0] nx;
        nx = ECW'(x) + ECW'(1);
        if (nx >= ec)
        begin
            wrap_inc = AW'(ccta_pkg::FIRST_DATA_CLUSTER);
        end
        else
        begin
            wrap_inc = AW'(nx);
        end
    endfunction

    ccta_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (32'(cluster_count_reg) < 32'(ccta_pkg::CLUSTER_COUNT_MIN))
        begin
            ec_comb = ECW'(ccta_pkg::CLUSTER_COUNT_MIN);
        end
        else if (32'(cluster_count_reg) > 32'(TABLE_DEPTH))
        begin
            ec_comb = ECW'(TABLE_DEPTH);
        end
        else
        begin
            ec_comb = ECW'(cluster_count_reg);
        end
    end

    assign in_stall   = (state_reg != ccta_pkg::S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign cl_bad     = 32'(cluster) >= 32'(ec_comb);
    assign oc_bad     = 32'(other_cluster) >= 32'(ec_comb);
    assign scan_inc   = wrap_inc(scan_reg, ec_reg);
    assign cursor_inc = ECW'(cursor_reg) + ECW'(1);
    assign scan_last  = (ECW'(scan_reg) + ECW'(1)) == ec_reg;
    assign rd_free    = ram_rdata == ccta_pkg::ENTRY_FREE;
    assign rd_eof     = ram_rdata == ccta_pkg::ENTRY_EOC;
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (cursor_inc < ECW'(ccta_pkg::FIRST_DATA_CLUSTER) || cursor_inc >= ec_reg)
        begin
            alloc_start = AW'(ccta_pkg::FIRST_DATA_CLUSTER);
        end
        else
        begin
            alloc_start = AW'(cursor_inc);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ccta_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (ccta_pkg::func_t'(func))
                        ccta_pkg::FN_FORMAT:
                            state_next = ccta_pkg::S_FMT;
                        ccta_pkg::FN_LOAD, ccta_pkg::FN_SET_END, ccta_pkg::FN_SET_FREE:
                            state_next = cl_bad ? ccta_pkg::S_DONE : ccta_pkg::S_WR;
                        ccta_pkg::FN_READ:
                            state_next = cl_bad ? ccta_pkg::S_DONE : ccta_pkg::S_RD;
                        ccta_pkg::FN_ALLOC, ccta_pkg::FN_ALLOC_CHAIN:
                            state_next = ccta_pkg::S_AL_RD;
                        ccta_pkg::FN_APPEND:
                            state_next = (cl_bad || oc_bad) ? ccta_pkg::S_DONE
                                                            : ccta_pkg::S_WK_RD;
                        ccta_pkg::FN_LENGTH:
                            state_next = cl_bad ? ccta_pkg::S_DONE : ccta_pkg::S_WK_RD;
                        ccta_pkg::FN_COUNT_FREE:
                            state_next = ccta_pkg::S_CF_RD;
                        default:
                            state_next = ccta_pkg::S_DONE;
                    endcase
                end
            end
            ccta_pkg::S_FMT:
                state_next = scan_last ? ccta_pkg::S_FMT0 : ccta_pkg::S_FMT;
            ccta_pkg::S_FMT0:
                state_next = ccta_pkg::S_FMT1;
            ccta_pkg::S_FMT1, ccta_pkg::S_WR, ccta_pkg::S_RD_CHK, ccta_pkg::S_WK_WR:
                state_next = ccta_pkg::S_DONE;
            ccta_pkg::S_RD:
                state_next = ccta_pkg::S_RD_CHK;
            ccta_pkg::S_AL_RD:
                state_next = ccta_pkg::S_AL_CHK;
            ccta_pkg::S_AL_CHK:
            begin
                if (rd_free)
                begin
                    if (got_cnt_reg != 13'd0)
                    begin
                        state_next = ccta_pkg::S_AL_LINK;
                    end
                    else if (got_cnt_reg + 13'd1 == want_reg)
                    begin
                        state_next = ccta_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = ccta_pkg::S_AL_RD;
                    end
                end
                else if (n_reg == ec_reg - ECW'(3))
                begin
                    state_next = ccta_pkg::S_DONE;
                end
                else
                begin
                    state_next = ccta_pkg::S_AL_RD;
                end
            end
            ccta_pkg::S_AL_LINK:
                state_next = (got_cnt_reg + 13'd1 == want_reg) ? ccta_pkg::S_DONE
                                                                : ccta_pkg::S_AL_RD;
            ccta_pkg::S_WK_RD:
                state_next = ccta_pkg::S_WK_CHK;
            ccta_pkg::S_WK_CHK:
            begin
                if (rd_eof)
                begin
                    state_next = (func_reg == ccta_pkg::FN_APPEND) ? ccta_pkg::S_WK_WR
                                                                    : ccta_pkg::S_DONE;
                end
                else if (steps_reg >= ec_reg || ram_rdata >= 32'(ec_reg))
                begin
                    state_next = ccta_pkg::S_DONE;
                end
                else
                begin
                    state_next = ccta_pkg::S_WK_RD;
                end
            end
            ccta_pkg::S_CF_RD:
                state_next = ccta_pkg::S_CF_CHK;
            ccta_pkg::S_CF_CHK:
                state_next = scan_last ? ccta_pkg::S_DONE : ccta_pkg::S_CF_RD;
            ccta_pkg::S_DONE:
                state_next = out_free ? ccta_pkg::S_IDLE : ccta_pkg::S_DONE;
            default:
                state_next = ccta_pkg::S_IDLE;
        endcase
    end

    // table port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = scan_reg;
        ram_wdata = ccta_pkg::ENTRY_FREE;
        unique case (state_reg)
            ccta_pkg::S_FMT:
            begin
                ram_we = 1'b1;
            end
            ccta_pkg::S_FMT0:
            begin
                ram_we    = 1'b1;
                ram_addr  = AW'(0);
                ram_wdata = ccta_pkg::MEDIA_WORD;
            end
            ccta_pkg::S_FMT1:
            begin
                ram_we    = 1'b1;
                ram_addr  = AW'(1);
                ram_wdata = ccta_pkg::ENTRY_EOC;
            end
            ccta_pkg::S_WR:
            begin
                ram_we    = 1'b1;
                ram_addr  = cur_reg;
                ram_wdata = wr_data_reg;
            end
            ccta_pkg::S_RD, ccta_pkg::S_WK_RD:
            begin
                ram_addr = cur_reg;
            end
            ccta_pkg::S_AL_RD:
            begin
                ram_addr = (n_reg == '0) ? alloc_start : scan_reg;
            end
            ccta_pkg::S_AL_CHK:
            begin
                ram_we    = rd_free;
                ram_wdata = ccta_pkg::ENTRY_EOC;
            end
            ccta_pkg::S_AL_LINK:
            begin
                ram_we    = 1'b1;
                ram_addr  = prev_reg;
                ram_wdata = 32'(cursor_reg);
            end
            ccta_pkg::S_WK_WR:
            begin
                ram_we    = 1'b1;
                ram_addr  = cur_reg;
                ram_wdata = oc_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ccta_pkg::S_IDLE;
            cluster_count_reg <= ccta_pkg::CLUSTER_COUNT_RESET;
            cursor_reg        <= AW'(1);
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                cluster_count_reg <= cfg_write_data;
            end
            if (state_reg == ccta_pkg::S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ccta_pkg::S_FMT1)
            begin
                cursor_reg <= AW'(1);
            end
            if (state_reg == ccta_pkg::S_AL_CHK && rd_free)
            begin
                cursor_reg <= scan_reg;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ccta_pkg::S_DONE && out_free)
        begin
            status_reg       <= st_reg;
            result_value_reg <= res_reg;
        end
        unique case (state_reg)
            ccta_pkg::S_IDLE:
            begin
                func_reg     <= ccta_pkg::func_t'(func);
                ec_reg       <= ec_comb;
                cur_reg      <= AW'(cluster);
                oc_reg       <= 32'(other_cluster);
                scan_reg     <= AW'(ccta_pkg::FIRST_DATA_CLUSTER);
                n_reg        <= '0;
                steps_reg    <= '0;
                cnt_free_reg <= '0;
                got_cnt_reg  <= 13'd0;
                res_reg      <= 32'd0;
                want_reg     <= (ccta_pkg::func_t'(func) == ccta_pkg::FN_ALLOC_CHAIN
                                 && chain_length != 13'd0) ? chain_length : 13'd1;
                unique case (ccta_pkg::func_t'(func))
                    ccta_pkg::FN_SET_END:  wr_data_reg <= ccta_pkg::ENTRY_EOC;
                    ccta_pkg::FN_SET_FREE: wr_data_reg <= ccta_pkg::ENTRY_FREE;
                    default:               wr_data_reg <= entry_value;
                endcase
                unique case (ccta_pkg::func_t'(func))
                    ccta_pkg::FN_LOAD, ccta_pkg::FN_SET_END, ccta_pkg::FN_SET_FREE,
                    ccta_pkg::FN_READ, ccta_pkg::FN_LENGTH:
                        st_reg <= cl_bad ? ccta_pkg::ST_RANGE : ccta_pkg::ST_OK;
                    ccta_pkg::FN_APPEND:
                        st_reg <= (cl_bad || oc_bad) ? ccta_pkg::ST_RANGE
                                                     : ccta_pkg::ST_OK;
                    default:
                        st_reg <= ccta_pkg::ST_OK;
                endcase
            end
            ccta_pkg::S_FMT:
                scan_reg <= scan_inc;
            ccta_pkg::S_RD_CHK:
                res_reg <= ram_rdata;
            ccta_pkg::S_AL_RD:
            begin
                if (n_reg == '0)
                begin
                    scan_reg <= alloc_start;
                end
            end
            ccta_pkg::S_AL_CHK:
            begin
                if (rd_free)
                begin
                    n_reg <= '0;
                    if (got_cnt_reg == 13'd0)
                    begin
                        res_reg     <= 32'(scan_reg);
                        prev_reg    <= scan_reg;
                        got_cnt_reg <= 13'd1;
                    end
                end
                else
                begin
                    n_reg    <= n_reg + ECW'(1);
                    scan_reg <= scan_inc;
                    if (n_reg == ec_reg - ECW'(3))
                    begin
                        st_reg <= ccta_pkg::ST_FULL;
                    end
                end
            end
            ccta_pkg::S_AL_LINK:
            begin
                prev_reg    <= cursor_reg;
                got_cnt_reg <= got_cnt_reg + 13'd1;
            end
            ccta_pkg::S_WK_CHK:
            begin
                if (rd_eof)
                begin
                    if (func_reg == ccta_pkg::FN_LENGTH)
                    begin
                        res_reg <= 32'(steps_reg) + 32'd1;
                    end
                end
                else if (steps_reg >= ec_reg)
                begin
                    st_reg <= ccta_pkg::ST_LOOP;
                end
                else if (ram_rdata >= 32'(ec_reg))
                begin
                    st_reg <= ccta_pkg::ST_RANGE;
                end
                else
                begin
                    cur_reg   <= AW'(ram_rdata);
                    steps_reg <= steps_reg + ECW'(1);
                end
            end
            ccta_pkg::S_CF_CHK:
            begin
                scan_reg <= scan_inc;
                if (rd_free)
                begin
                    cnt_free_reg <= cnt_free_reg + ECW'(1);
                    if (scan_last)
                    begin
                        res_reg <= 32'(cnt_free_reg) + 32'd1;
                    end
                end
                else if (scan_last)
                begin
                    res_reg <= 32'(cnt_free_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_value = result_value_reg;

endmodule
`default_nettype wire

@@ tb/sv/cluster_chain_table_allocator_core_tb.sv @@
// cluster_chain_table_allocator_core_tb: self-checking bench for the cluster link table
// allocator; needs ccta_pkg and cluster_chain_table_allocator_core
// a behavioral table predictor checks every response under random request and response gaps
`timescale 1ns / 100ps
module cluster_chain_table_allocator_core_tb;

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] value;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  func = '0;
    logic [11:0] cluster = '0;
    logic [11:0] other_cluster = '0;
    logic [31:0] entry_value = '0;
    logic [12:0] chain_length = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] result_value;
    logic        cfg_write_en = 1'b0;
    logic [12:0] cfg_write_data = '0;

    logic [31:0] link_tbl [0:4095];
    int          fit_cursor = 1;
    int          count_reg = 4096;
    outcome_t    outcome_q [$];
    int          chain_heads [$];
    int          errors = 0;
    int          burst_left = 0;
    logic [7:0]  stall_phase = '0;

    cluster_chain_table_allocator_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .cluster(cluster), .other_cluster(other_cluster),
        .entry_value(entry_value), .chain_length(chain_length),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .result_value(result_value),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #100ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int eff_count();
        if (count_reg < 3)
            return 3;
        if (count_reg > 4096)
            return 4096;
        return count_reg;
    endfunction

    function automatic bit take_free(input int ec, output int got);
        int i;
        i = fit_cursor + 1;
        if (i < ccta_pkg::FIRST_DATA_CLUSTER || i >= ec)
            i = ccta_pkg::FIRST_DATA_CLUSTER;
        for (int n = 0; n < ec - ccta_pkg::FIRST_DATA_CLUSTER; n++)
        begin
            if (link_tbl[i] == ccta_pkg::ENTRY_FREE)
            begin
                link_tbl[i] = ccta_pkg::ENTRY_EOC;
                fit_cursor = i;
                got = i;
                return 1'b1;
            end
            i++;
            if (i >= ec)
                i = ccta_pkg::FIRST_DATA_CLUSTER;
        end
        return 1'b0;
    endfunction

    function automatic ccta_pkg::status_t chase(input int ec, input int start,
                                                output int last, output int len);
        int c;
        int steps;
        c = start;
        steps = 0;
        while (link_tbl[c] != ccta_pkg::ENTRY_EOC)
        begin
            if (steps >= ec)
                return ccta_pkg::ST_LOOP;
            if (link_tbl[c] >= ec)
                return ccta_pkg::ST_RANGE;
            c = link_tbl[c];
            steps++;
        end
        last = c;
        len = steps + 1;
        return ccta_pkg::ST_OK;
    endfunction

    function automatic outcome_t predict_table(input logic [3:0] f, input int cl,
                                               input int oc, input logic [31:0] val,
                                               input int want);
        outcome_t o;
        int ec;
        int got;
        int prev;
        int last;
        int len;
        ec = eff_count();
        o.st = ccta_pkg::ST_OK;
        o.value = '0;
        case (f)
            ccta_pkg::FN_FORMAT:
            begin
                for (int i = ccta_pkg::FIRST_DATA_CLUSTER; i < ec; i++)
                    link_tbl[i] = ccta_pkg::ENTRY_FREE;
                link_tbl[0] = ccta_pkg::MEDIA_WORD;
                link_tbl[1] = ccta_pkg::ENTRY_EOC;
                fit_cursor = 1;
            end
            ccta_pkg::FN_LOAD:
                if (cl >= ec) o.st = ccta_pkg::ST_RANGE; else link_tbl[cl] = val;
            ccta_pkg::FN_ALLOC:
                if (take_free(ec, got)) o.value = got; else o.st = ccta_pkg::ST_FULL;
            ccta_pkg::FN_ALLOC_CHAIN:
            begin
                if (want == 0)
                    want = 1;
                if (!take_free(ec, got))
                    o.st = ccta_pkg::ST_FULL;
                else
                begin
                    o.value = got;
                    prev = got;
                    for (int i = 1; i < want; i++)
                    begin
                        if (!take_free(ec, got))
                        begin
                            o.st = ccta_pkg::ST_FULL;
                            break;
                        end
                        link_tbl[prev] = got;
                        prev = got;
                    end
                end
            end
            ccta_pkg::FN_APPEND:
                if (cl >= ec || oc >= ec)
                    o.st = ccta_pkg::ST_RANGE;
                else
                begin
                    o.st = chase(ec, cl, last, len);
                    if (o.st == ccta_pkg::ST_OK)
                        link_tbl[last] = oc;
                end
            ccta_pkg::FN_LENGTH:
                if (cl >= ec)
                    o.st = ccta_pkg::ST_RANGE;
                else
                begin
                    o.st = chase(ec, cl, last, len);
                    if (o.st == ccta_pkg::ST_OK)
                        o.value = len;
                end
            ccta_pkg::FN_SET_END:
                if (cl >= ec) o.st = ccta_pkg::ST_RANGE; else link_tbl[cl] = ccta_pkg::ENTRY_EOC;
            ccta_pkg::FN_SET_FREE:
                if (cl >= ec) o.st = ccta_pkg::ST_RANGE; else link_tbl[cl] = ccta_pkg::ENTRY_FREE;
            ccta_pkg::FN_READ:
                if (cl >= ec) o.st = ccta_pkg::ST_RANGE; else o.value = link_tbl[cl];
            ccta_pkg::FN_COUNT_FREE:
                for (int i = ccta_pkg::FIRST_DATA_CLUSTER; i < ec; i++)
                    if (link_tbl[i] == ccta_pkg::ENTRY_FREE)
                        o.value++;
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // response pacing: quiet stretches alternate with random stalling
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 8'd1;
        out_stall <= (stall_phase[7:6] == 2'd0) ? 1'b0 : ($urandom_range(0, 2) == 0);
    end

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("unexpected response status=%0d result_value=%h", status, result_value);
                errors++;
            end
            else
            begin
                e = outcome_q.pop_front();
                if (status !== e.st)
                begin
                    $error("status expected %0d actual %0d", e.st, status);
                    errors++;
                end
                if (result_value !== e.value)
                begin
                    $error("result_value expected %h actual %h", e.value, result_value);
                    errors++;
                end
            end
        end
    end

    task automatic send_req(input logic [3:0] f, input int cl, input int oc,
                            input logic [31:0] val, input int want);
        outcome_t o;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        func <= f;
        cluster <= cl[11:0];
        other_cluster <= oc[11:0];
        entry_value <= val;
        chain_length <= want[12:0];
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        burst_left--;
        o = predict_table(f, int'(cl[11:0]), int'(oc[11:0]), val, int'(want[12:0]));
        outcome_q.push_back(o);
        if ((f == ccta_pkg::FN_ALLOC || f == ccta_pkg::FN_ALLOC_CHAIN) && o.value != 0)
        begin
            chain_heads.push_back(o.value);
            if (chain_heads.size() > 16)
                void'(chain_heads.pop_front());
        end
        if (f == ccta_pkg::FN_FORMAT)
            chain_heads.delete();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (outcome_q.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_count(input logic [12:0] v);
        drain();
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        count_reg = int'(v);
        send_req(ccta_pkg::FN_FORMAT, 0, 0, 32'd0, 0);
    endtask

    function automatic int pick_cluster();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 4095);
        if (chain_heads.size() > 0 && $urandom_range(0, 1) == 0)
            return chain_heads[$urandom_range(0, chain_heads.size() - 1)];
        return $urandom_range(0, eff_count() - 1);
    endfunction

    task automatic test_directed_full_table();
        int head;
        send_req(ccta_pkg::FN_FORMAT, 0, 0, 32'd0, 0);
        send_req(ccta_pkg::FN_READ, 0, 0, 32'd0, 0);
        send_req(ccta_pkg::FN_READ, 1, 0, 32'd0, 0);
        send_req(ccta_pkg::FN_LOAD, 4095, 0, 32'hFFFF_FFFF, 0);
        send_req(ccta_pkg::FN_READ, 4095, 0, 32'd0, 0);
        send_req(ccta_pkg::FN_ALLOC, 0, 0, 32'd0, 0);
        send_req(ccta_pkg::FN_ALLOC_CHAIN, 0, 0, 32'd0, 0);
        send_req(ccta_pkg::FN_ALLOC_CHAIN, 0, 0, 32'd0, 5);
        head = fit_cursor - 4;
        send_req(ccta_pkg::FN_LENGTH, head, 0, 32'd0, 0);
        send_req(ccta_pkg::FN_APPEND, head, 2, 32'd0, 0);
        send_req(ccta_pkg::FN_LENGTH, head, 0, 32'd0, 0);
        send_req(ccta_pkg::FN_SET_END, 2, 0, 32'd0, 0);
        send_req(ccta_pkg::FN_SET_FREE, 3, 0, 32'd0, 0);
        send_req(ccta_pkg::FN_COUNT_FREE, 0, 0, 32'd0, 0);
        send_req(4'd15, 4095, 4095, 32'hFFFF_FFFF, 8191);
        send_req(ccta_pkg::FN_LOAD, 100, 0, 32'd100, 0);
        send_req(ccta_pkg::FN_LENGTH, 100, 0, 32'd0, 0);
    endtask

    task automatic test_directed_small_table();
        set_count(13'd8);
        send_req(ccta_pkg::FN_READ, 4095, 0, 32'd0, 0);
        send_req(ccta_pkg::FN_APPEND, 1, 4095, 32'd0, 0);
        send_req(ccta_pkg::FN_LOAD, 3, 0, 32'd100, 0);
        send_req(ccta_pkg::FN_LENGTH, 3, 0, 32'd0, 0);
        send_req(ccta_pkg::FN_ALLOC_CHAIN, 0, 0, 32'd0, 4096);
        send_req(ccta_pkg::FN_ALLOC, 0, 0, 32'd0, 0);
        send_req(ccta_pkg::FN_ALLOC_CHAIN, 0, 0, 32'd0, 3);
        send_req(ccta_pkg::FN_COUNT_FREE, 0, 0, 32'd0, 0);
    endtask

    task automatic test_random(input logic [12:0] cnt, input int n, input int maxlen);
        int r;
        int ec;
        logic [31:0] v;
        set_count(cnt);
        ec = eff_count();
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                send_req(ccta_pkg::FN_ALLOC, pick_cluster(), 0, $urandom, 0);
            else if (r < 35)
                send_req(ccta_pkg::FN_ALLOC_CHAIN, 0, 0, 32'd0,
                         ($urandom_range(0, 19) == 0 && ec < 64) ?
                         $urandom_range(0, 8191) : $urandom_range(0, maxlen));
            else if (r < 47)
                send_req(ccta_pkg::FN_APPEND, pick_cluster(), pick_cluster(), 32'd0, 0);
            else if (r < 60)
                send_req(ccta_pkg::FN_LENGTH, pick_cluster(), 0, 32'd0, 0);
            else if (r < 67)
                send_req(ccta_pkg::FN_SET_FREE, pick_cluster(), 0, 32'd0, 0);
            else if (r < 72)
                send_req(ccta_pkg::FN_SET_END, pick_cluster(), 0, 32'd0, 0);
            else if (r < 82)
                send_req(ccta_pkg::FN_READ, pick_cluster(), 0, 32'd0, 0);
            else if (r < 88)
            begin
                case ($urandom_range(0, 2))
                    0: v = $urandom;
                    1: v = $urandom_range(0, ec - 1);
                    default: v = ccta_pkg::ENTRY_EOC;
                endcase
                send_req(ccta_pkg::FN_LOAD, pick_cluster(), 0, v, 0);
            end
            else if (r < 93)
                send_req(ccta_pkg::FN_COUNT_FREE, 0, 0, 32'd0, 0);
            else if (r < 96)
                send_req(ccta_pkg::FN_FORMAT, 0, 0, 32'd0, 0);
            else
                send_req(4'($urandom_range(10, 15)), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom, $urandom_range(0, 8191));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_full_table();
        test_directed_small_table();
        test_random(13'd0, 150, 4);
        test_random(13'd8, 300, 8);
        test_random(13'd37, 680, 40);
        test_random(13'd200, 600, 64);
        test_random(13'h1FFF, 25, 32);
        test_random(13'd4096, 15, 16);
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ cluster_chain_table_allocator_core.f @@
hw/rtl/ccta_pkg.sv
hw/rtl/ccta_table_ram.sv
hw/rtl/cluster_chain_table_allocator_core.sv
tb/sv/cluster_chain_table_allocator_core_tb.sv
